FILE: rtl/core/rv32sd_pkg.sv
// ----------------------------------------------------------------------------
// rv32sd_pkg
// Shared types and encodings for the rv32 subset instruction decoder.
// ----------------------------------------------------------------------------
package rv32sd_pkg;

    localparam int unsigned XLEN       = 32;
    localparam int unsigned PROG_WIDTH = 31;
    localparam int unsigned REG_WIDTH  = 5;
    localparam int unsigned OP_WIDTH   = 6;
    localparam int unsigned ST_WIDTH   = 2;

    localparam logic [PROG_WIDTH-1:0] PROG_WORDS_RESET = '0;

    // major opcodes
    localparam logic [6:0] OPC_REG    = 7'b0110011;
    localparam logic [6:0] OPC_FP     = 7'b1010011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_FSTORE = 7'b0100111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_INB    = 7'b0000010;
    localparam logic [6:0] OPC_OUTB   = 7'b0000110;
    localparam logic [6:0] OPC_IMM    = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_FLOAD  = 7'b0000111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;

    // funct7 codes
    localparam logic [6:0] F7_ZERO  = 7'h00;
    localparam logic [6:0] F7_ALT   = 7'h20;
    localparam logic [6:0] F7_FADD  = 7'h00;
    localparam logic [6:0] F7_FSUB  = 7'h04;
    localparam logic [6:0] F7_FMUL  = 7'h08;
    localparam logic [6:0] F7_FDIV  = 7'h0c;
    localparam logic [6:0] F7_FSQRT = 7'h2c;
    localparam logic [6:0] F7_FSGNJ = 7'h10;
    localparam logic [6:0] F7_FCVTW = 7'h60;
    localparam logic [6:0] F7_FCMP  = 7'h50;
    localparam logic [6:0] F7_FCVTS = 7'h68;
    localparam logic [6:0] F7_FMVSX = 7'h78;

    // funct3 codes
    localparam logic [2:0] F3_ZERO = 3'd0;
    localparam logic [2:0] F3_ONE  = 3'd1;
    localparam logic [2:0] F3_TWO  = 3'd2;
    localparam logic [2:0] F3_FOUR = 3'd4;
    localparam logic [2:0] F3_FIVE = 3'd5;
    localparam logic [2:0] F3_SIX  = 3'd6;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD    = 6'd0,
        OP_SUB    = 6'd1,
        OP_OR     = 6'd2,
        OP_FADD   = 6'd3,
        OP_FSUB   = 6'd4,
        OP_FMUL   = 6'd5,
        OP_FDIV   = 6'd6,
        OP_FSQRT  = 6'd7,
        OP_FSGNJ  = 6'd8,
        OP_FSGNJN = 6'd9,
        OP_FSGNJX = 6'd10,
        OP_FCVTWS = 6'd11,
        OP_FEQ    = 6'd12,
        OP_FLE    = 6'd13,
        OP_FCVTSW = 6'd14,
        OP_FMVSX  = 6'd15,
        OP_SW     = 6'd16,
        OP_FSW    = 6'd17,
        OP_BEQ    = 6'd18,
        OP_BNE    = 6'd19,
        OP_BLT    = 6'd20,
        OP_BGE    = 6'd21,
        OP_LUI    = 6'd22,
        OP_JAL    = 6'd23,
        OP_HALT   = 6'd24,
        OP_INB    = 6'd25,
        OP_OUTB   = 6'd26,
        OP_ADDI   = 6'd27,
        OP_SLLI   = 6'd28,
        OP_SRAI   = 6'd29,
        OP_LW     = 6'd30,
        OP_FLW    = 6'd31,
        OP_JALR   = 6'd32
    } op_t;

    typedef enum logic [ST_WIDTH-1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        IMM_NONE  = 3'd0,
        IMM_I     = 3'd1,
        IMM_S     = 3'd2,
        IMM_B     = 3'd3,
        IMM_U     = 3'd4,
        IMM_J     = 3'd5,
        IMM_SHAMT = 3'd6
    } imm_fmt_t;

    // after the range check
    typedef struct packed {
        logic             out_of_range;
        logic [XLEN-1:0]  word;
    } range_item_t;

    // after the operation decode
    typedef struct packed {
        logic             out_of_range;
        logic             bad;
        op_t              op;
        imm_fmt_t         fmt;
        logic [XLEN-1:0]  word;
    } op_item_t;

    // final result
    typedef struct packed {
        status_t              status;
        logic [XLEN-1:0]      immediate;
        logic [REG_WIDTH-1:0] src2_reg;
        logic [REG_WIDTH-1:0] src1_reg;
        logic [REG_WIDTH-1:0] dest_reg;
        op_t                  operation;
    } result_t;

    localparam int unsigned IN_TDATA_WIDTH  = 2 * XLEN;
    localparam int unsigned OUT_TDATA_WIDTH = ((($bits(result_t)) + 7) / 8) * 8;

endpackage

FILE: rtl/core/rv32sd_range_stage.sv
// ----------------------------------------------------------------------------
// rv32sd_range_stage
// First pipeline stage: compares the word index of pc against the program size.
// ----------------------------------------------------------------------------
module rv32sd_range_stage (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [rv32sd_pkg::PROG_WIDTH-1:0]    program_words,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [rv32sd_pkg::XLEN-1:0]          in_pc,
    input  logic [rv32sd_pkg::XLEN-1:0]          in_word,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output rv32sd_pkg::range_item_t              out_item
);

    logic                    valid_reg;
    rv32sd_pkg::range_item_t item_reg;
    rv32sd_pkg::range_item_t item_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        item_next.word         = in_word;
        item_next.out_of_range = ({1'b0, in_pc[rv32sd_pkg::XLEN-1:2]} >= program_words);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: rtl/core/rv32sd_op_stage.sv
// ----------------------------------------------------------------------------
// rv32sd_op_stage
// Second pipeline stage: matches opcode, funct3 and funct7 to an operation and
// picks the immediate format.
// ----------------------------------------------------------------------------
module rv32sd_op_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  rv32sd_pkg::range_item_t    in_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output rv32sd_pkg::op_item_t       out_item
);

    logic                 valid_reg;
    rv32sd_pkg::op_item_t item_reg;
    rv32sd_pkg::op_item_t item_next;

    logic [6:0] opc;
    logic [4:0] rd;
    logic [2:0] f3;
    logic [4:0] rs1;
    logic [4:0] rs2;
    logic [6:0] f7;

    assign in_ready = !valid_reg || out_ready;

    assign opc = in_item.word[6:0];
    assign rd  = in_item.word[11:7];
    assign f3  = in_item.word[14:12];
    assign rs1 = in_item.word[19:15];
    assign rs2 = in_item.word[24:20];
    assign f7  = in_item.word[31:25];

    always_comb begin
        item_next.out_of_range = in_item.out_of_range;
        item_next.word         = in_item.word;
        item_next.bad          = 1'b0;
        item_next.op           = rv32sd_pkg::OP_ADD;
        item_next.fmt          = rv32sd_pkg::IMM_NONE;
        priority if (opc == rv32sd_pkg::OPC_REG) begin
            priority if (f3 == rv32sd_pkg::F3_ZERO && f7 == rv32sd_pkg::F7_ZERO)
                item_next.op = rv32sd_pkg::OP_ADD;
            else if (f3 == rv32sd_pkg::F3_ZERO && f7 == rv32sd_pkg::F7_ALT)
                item_next.op = rv32sd_pkg::OP_SUB;
            else if (f3 == rv32sd_pkg::F3_SIX && f7 == rv32sd_pkg::F7_ZERO)
                item_next.op = rv32sd_pkg::OP_OR;
            else
                item_next.bad = 1'b1;
        end else if (opc == rv32sd_pkg::OPC_FP) begin
            priority if (f7 == rv32sd_pkg::F7_FADD && f3 == rv32sd_pkg::F3_ZERO)
                item_next.op = rv32sd_pkg::OP_FADD;
            else if (f7 == rv32sd_pkg::F7_FSUB && f3 == rv32sd_pkg::F3_ZERO)
                item_next.op = rv32sd_pkg::OP_FSUB;
            else if (f7 == rv32sd_pkg::F7_FMUL && f3 == rv32sd_pkg::F3_ZERO)
                item_next.op = rv32sd_pkg::OP_FMUL;
            else if (f7 == rv32sd_pkg::F7_FDIV && f3 == rv32sd_pkg::F3_ZERO)
                item_next.op = rv32sd_pkg::OP_FDIV;
            else if (f7 == rv32sd_pkg::F7_FSQRT && f3 == rv32sd_pkg::F3_ZERO && rs2 == '0)
                item_next.op = rv32sd_pkg::OP_FSQRT;
            else if (f7 == rv32sd_pkg::F7_FSGNJ && f3 == rv32sd_pkg::F3_ZERO)
                item_next.op = rv32sd_pkg::OP_FSGNJ;
            else if (f7 == rv32sd_pkg::F7_FSGNJ && f3 == rv32sd_pkg::F3_ONE)
                item_next.op = rv32sd_pkg::OP_FSGNJN;
            else if (f7 == rv32sd_pkg::F7_FSGNJ && f3 == rv32sd_pkg::F3_TWO)
                item_next.op = rv32sd_pkg::OP_FSGNJX;
            else if (f7 == rv32sd_pkg::F7_FCVTW && f3 == rv32sd_pkg::F3_ZERO && rs2 == '0)
                item_next.op = rv32sd_pkg::OP_FCVTWS;
            else if (f7 == rv32sd_pkg::F7_FCMP && f3 == rv32sd_pkg::F3_TWO)
                item_next.op = rv32sd_pkg::OP_FEQ;
            else if (f7 == rv32sd_pkg::F7_FCMP && f3 == rv32sd_pkg::F3_ZERO)
                item_next.op = rv32sd_pkg::OP_FLE;
            else if (f7 == rv32sd_pkg::F7_FCVTS && f3 == rv32sd_pkg::F3_ZERO && rs2 == '0)
                item_next.op = rv32sd_pkg::OP_FCVTSW;
            else if (f7 == rv32sd_pkg::F7_FMVSX && f3 == rv32sd_pkg::F3_ZERO && rs2 == '0)
                item_next.op = rv32sd_pkg::OP_FMVSX;
            else
                item_next.bad = 1'b1;
        end else if (opc == rv32sd_pkg::OPC_STORE || opc == rv32sd_pkg::OPC_FSTORE) begin
            item_next.fmt = rv32sd_pkg::IMM_S;
            if (f3 == rv32sd_pkg::F3_TWO) begin
                item_next.op = (opc == rv32sd_pkg::OPC_STORE) ? rv32sd_pkg::OP_SW
                                                              : rv32sd_pkg::OP_FSW;
            end else begin
                item_next.bad = 1'b1;
            end
        end else if (opc == rv32sd_pkg::OPC_BRANCH) begin
            item_next.fmt = rv32sd_pkg::IMM_B;
            priority if (f3 == rv32sd_pkg::F3_ZERO)
                item_next.op = rv32sd_pkg::OP_BEQ;
            else if (f3 == rv32sd_pkg::F3_ONE)
                item_next.op = rv32sd_pkg::OP_BNE;
            else if (f3 == rv32sd_pkg::F3_FOUR)
                item_next.op = rv32sd_pkg::OP_BLT;
            else if (f3 == rv32sd_pkg::F3_FIVE)
                item_next.op = rv32sd_pkg::OP_BGE;
            else
                item_next.bad = 1'b1;
        end else if (opc == rv32sd_pkg::OPC_LUI) begin
            item_next.op  = rv32sd_pkg::OP_LUI;
            item_next.fmt = rv32sd_pkg::IMM_U;
        end else if (opc == rv32sd_pkg::OPC_JAL) begin
            item_next.op  = rv32sd_pkg::OP_JAL;
            item_next.fmt = rv32sd_pkg::IMM_J;
        end else if (in_item.word == '0) begin
            item_next.op = rv32sd_pkg::OP_HALT;
        end else if (opc == rv32sd_pkg::OPC_INB && f7 == '0 && rs2 == '0 && rs1 == '0
                     && f3 == rv32sd_pkg::F3_ZERO) begin
            item_next.op = rv32sd_pkg::OP_INB;
        end else if (opc == rv32sd_pkg::OPC_OUTB && f7 == '0 && rs1 == '0
                     && f3 == rv32sd_pkg::F3_ZERO && rd == '0) begin
            item_next.op = rv32sd_pkg::OP_OUTB;
        end else if (opc == rv32sd_pkg::OPC_IMM && f3 == rv32sd_pkg::F3_ZERO) begin
            item_next.op  = rv32sd_pkg::OP_ADDI;
            item_next.fmt = rv32sd_pkg::IMM_I;
        end else if (opc == rv32sd_pkg::OPC_IMM && f3 == rv32sd_pkg::F3_ONE
                     && f7 == rv32sd_pkg::F7_ZERO) begin
            item_next.op  = rv32sd_pkg::OP_SLLI;
            item_next.fmt = rv32sd_pkg::IMM_SHAMT;
        end else if (opc == rv32sd_pkg::OPC_IMM && f3 == rv32sd_pkg::F3_FIVE
                     && f7 == rv32sd_pkg::F7_ALT) begin
            item_next.op  = rv32sd_pkg::OP_SRAI;
            item_next.fmt = rv32sd_pkg::IMM_SHAMT;
        end else if (opc == rv32sd_pkg::OPC_LOAD && f3 == rv32sd_pkg::F3_TWO) begin
            item_next.op  = rv32sd_pkg::OP_LW;
            item_next.fmt = rv32sd_pkg::IMM_I;
        end else if (opc == rv32sd_pkg::OPC_FLOAD && f3 == rv32sd_pkg::F3_TWO) begin
            item_next.op  = rv32sd_pkg::OP_FLW;
            item_next.fmt = rv32sd_pkg::IMM_I;
        end else if (opc == rv32sd_pkg::OPC_JALR && f3 == rv32sd_pkg::F3_ZERO) begin
            item_next.op  = rv32sd_pkg::OP_JALR;
            item_next.fmt = rv32sd_pkg::IMM_I;
        end else begin
            item_next.bad = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: rtl/core/rv32sd_result_stage.sv
// ----------------------------------------------------------------------------
// rv32sd_result_stage
// Third pipeline stage: builds the immediate, applies the status and holds the
// result for the output channel.
// ----------------------------------------------------------------------------
module rv32sd_result_stage (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  rv32sd_pkg::op_item_t    in_item,
    output logic                    out_valid,
    input  logic                    out_ready,
    output rv32sd_pkg::result_t     out_result
);

    logic                          valid_reg;
    rv32sd_pkg::result_t           result_reg;
    rv32sd_pkg::result_t           result_next;
    logic [rv32sd_pkg::XLEN-1:0]   w;
    logic [rv32sd_pkg::XLEN-1:0]   imm;

    assign in_ready = !valid_reg || out_ready;
    assign w        = in_item.word;

    always_comb begin
        unique case (in_item.fmt)
            rv32sd_pkg::IMM_I:     imm = {{20{w[31]}}, w[31:20]};
            rv32sd_pkg::IMM_S:     imm = {{20{w[31]}}, w[31:25], w[11:7]};
            rv32sd_pkg::IMM_B:     imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            rv32sd_pkg::IMM_U:     imm = {w[31:12], 12'b0};
            rv32sd_pkg::IMM_J:     imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            rv32sd_pkg::IMM_SHAMT: imm = {27'b0, w[24:20]};
            rv32sd_pkg::IMM_NONE:  imm = '0;
            default:               imm = '0;
        endcase
    end

    always_comb begin
        result_next.dest_reg  = w[11:7];
        result_next.src1_reg  = w[19:15];
        result_next.src2_reg  = w[24:20];
        result_next.operation = in_item.op;
        result_next.immediate = imm;
        priority if (in_item.out_of_range) begin
            result_next.dest_reg  = '0;
            result_next.src1_reg  = '0;
            result_next.src2_reg  = '0;
            result_next.operation = rv32sd_pkg::OP_ADD;
            result_next.immediate = '0;
            result_next.status    = rv32sd_pkg::ST_RANGE;
        end else if (in_item.bad) begin
            result_next.operation = rv32sd_pkg::OP_ADD;
            result_next.immediate = '0;
            result_next.status    = rv32sd_pkg::ST_INVALID;
        end else begin
            result_next.status    = rv32sd_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

FILE: rtl/core/rv32_subset_instruction_decoder.sv
// ----------------------------------------------------------------------------
// rv32_subset_instruction_decoder
// Decodes a fixed RV32I/F subset plus inb, outb and halt into an operation,
// register fields, an immediate and a status.
// ----------------------------------------------------------------------------
// Takes one transfer per cycle while m_tready is high and returns one result per
// input transfer, through one register stage each for the pc range check, the
// operation decode and the immediate and status build. Holding m_tready low
// fills the three stages, after which s_tready drops; nothing is lost or repeated.
// cfg_wr_data sets the number of loaded instruction words; a pc whose word
// index is at or above it is reported as out of range.
module rv32_subset_instruction_decoder (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // configuration
    input  logic                                       cfg_wr_en,
    input  logic [rv32sd_pkg::PROG_WIDTH-1:0]          cfg_wr_data,   // program_words
    // input channel
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic [rv32sd_pkg::IN_TDATA_WIDTH-1:0]      s_tdata,       // pc, instruction_word
    // result channel
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // operation, dest_reg, src1_reg, src2_reg, immediate, status, zero pad
    output logic [rv32sd_pkg::OUT_TDATA_WIDTH-1:0]     m_tdata
);

    logic [rv32sd_pkg::PROG_WIDTH-1:0] program_words_reg;

    logic                    range_valid;
    logic                    range_ready;
    rv32sd_pkg::range_item_t range_item;
    logic                    op_valid;
    logic                    op_ready;
    rv32sd_pkg::op_item_t    op_item;
    rv32sd_pkg::result_t     result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            program_words_reg <= rv32sd_pkg::PROG_WORDS_RESET;
        end else if (cfg_wr_en) begin
            program_words_reg <= cfg_wr_data;
        end
    end

    rv32sd_range_stage u_range (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .program_words (program_words_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_pc         (s_tdata[rv32sd_pkg::XLEN-1:0]),
        .in_word       (s_tdata[2*rv32sd_pkg::XLEN-1:rv32sd_pkg::XLEN]),
        .out_valid     (range_valid),
        .out_ready     (range_ready),
        .out_item      (range_item)
    );

    rv32sd_op_stage u_op (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (range_valid),
        .in_ready  (range_ready),
        .in_item   (range_item),
        .out_valid (op_valid),
        .out_ready (op_ready),
        .out_item  (op_item)
    );

    rv32sd_result_stage u_result (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (op_valid),
        .in_ready   (op_ready),
        .in_item    (op_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {{(rv32sd_pkg::OUT_TDATA_WIDTH - $bits(rv32sd_pkg::result_t)){1'b0}},
                      result};

endmodule

FILE: tb/rv32_subset_instruction_decoder_test.sv
// ----------------------------------------------------------------------------
// rv32_subset_instruction_decoder_test
// Self-checking testbench for the rv32 subset instruction decoder. Each
// accepted transfer is decoded by a behavioral model and the expected result
// is queued. Every result transfer is compared field by field with the oldest
// entry. The stimulus covers the reset program size, every operation, the
// out-of-range and invalid-encoding cases, and random instruction streams
// under several program sizes. Both sides idle at random, and there are long
// output stalls and full drains.
// ----------------------------------------------------------------------------
module rv32_subset_instruction_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rv32sd_pkg::*;

    localparam int    CLK_PERIOD   = 4;
    localparam int    PIPE_LATENCY = 3;
    localparam int    LONG_HOLD    = 64;
    localparam time   RUN_LIMIT    = 2_000_000;

    typedef enum int {
        FILL_ZERO,
        FILL_ONES,
        FILL_RANDOM
    } fill_t;

    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic [PROG_WIDTH-1:0]        cfg_wr_data = '0;
    logic                         s_tvalid    = 1'b0;
    logic                         s_tready;
    logic [IN_TDATA_WIDTH-1:0]    s_tdata     = '0;
    logic                         m_tvalid;
    logic                         m_tready    = 1'b0;
    logic [OUT_TDATA_WIDTH-1:0]   m_tdata;

    result_t                      pending_decodes[$];
    logic [PROG_WIDTH-1:0]        program_words_model = PROG_WORDS_RESET;
    int                           mismatch_count = 0;
    int                           burst_left     = 0;
    int                           hold_requests  = 0;
    int                           holds_served   = 0;
    int                           hold_left      = 0;
    int                           ready_mode     = 0;
    int                           ready_phase_left = 0;

    rv32_subset_instruction_decoder DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic result_t decode_instruction(input logic [31:0] pc,
                                                   input logic [31:0] word);
        result_t     r;
        logic [6:0]  opc;
        logic [6:0]  f7;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] i_imm;
        logic        bad;
        opc   = word[6:0];
        rd    = word[11:7];
        f3    = word[14:12];
        rs1   = word[19:15];
        rs2   = word[24:20];
        f7    = word[31:25];
        i_imm = {{20{word[31]}}, word[31:20]};
        bad   = 1'b0;
        r     = '0;
        r.operation = OP_ADD;
        r.status    = ST_OK;
        if ({1'b0, pc[31:2]} >= program_words_model) begin
            r.status = ST_RANGE;
            return r;
        end
        r.dest_reg = rd;
        r.src1_reg = rs1;
        r.src2_reg = rs2;
        if (opc == OPC_REG) begin
            if (f3 == F3_ZERO && f7 == F7_ZERO) r.operation = OP_ADD;
            else if (f3 == F3_ZERO && f7 == F7_ALT) r.operation = OP_SUB;
            else if (f3 == F3_SIX && f7 == F7_ZERO) r.operation = OP_OR;
            else bad = 1'b1;
        end else if (opc == OPC_FP) begin
            if (f7 == F7_FADD && f3 == F3_ZERO) r.operation = OP_FADD;
            else if (f7 == F7_FSUB && f3 == F3_ZERO) r.operation = OP_FSUB;
            else if (f7 == F7_FMUL && f3 == F3_ZERO) r.operation = OP_FMUL;
            else if (f7 == F7_FDIV && f3 == F3_ZERO) r.operation = OP_FDIV;
            else if (f7 == F7_FSQRT && f3 == F3_ZERO && rs2 == 5'd0) r.operation = OP_FSQRT;
            else if (f7 == F7_FSGNJ && f3 == F3_ZERO) r.operation = OP_FSGNJ;
            else if (f7 == F7_FSGNJ && f3 == F3_ONE) r.operation = OP_FSGNJN;
            else if (f7 == F7_FSGNJ && f3 == F3_TWO) r.operation = OP_FSGNJX;
            else if (f7 == F7_FCVTW && f3 == F3_ZERO && rs2 == 5'd0) r.operation = OP_FCVTWS;
            else if (f7 == F7_FCMP && f3 == F3_TWO) r.operation = OP_FEQ;
            else if (f7 == F7_FCMP && f3 == F3_ZERO) r.operation = OP_FLE;
            else if (f7 == F7_FCVTS && f3 == F3_ZERO && rs2 == 5'd0) r.operation = OP_FCVTSW;
            else if (f7 == F7_FMVSX && f3 == F3_ZERO && rs2 == 5'd0) r.operation = OP_FMVSX;
            else bad = 1'b1;
        end else if (opc == OPC_STORE || opc == OPC_FSTORE) begin
            r.immediate = {{20{word[31]}}, word[31:25], word[11:7]};
            if (f3 == F3_TWO) r.operation = (opc == OPC_STORE) ? OP_SW : OP_FSW;
            else bad = 1'b1;
        end else if (opc == OPC_BRANCH) begin
            r.immediate = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
            if (f3 == F3_ZERO) r.operation = OP_BEQ;
            else if (f3 == F3_ONE) r.operation = OP_BNE;
            else if (f3 == F3_FOUR) r.operation = OP_BLT;
            else if (f3 == F3_FIVE) r.operation = OP_BGE;
            else bad = 1'b1;
        end else if (opc == OPC_LUI) begin
            r.operation = OP_LUI;
            r.immediate = {word[31:12], 12'd0};
        end else if (opc == OPC_JAL) begin
            r.operation = OP_JAL;
            r.immediate = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
        end else if (word == 32'd0) begin
            r.operation = OP_HALT;
        end else if (opc == OPC_INB && f7 == F7_ZERO && rs2 == 5'd0 && rs1 == 5'd0
                     && f3 == F3_ZERO) begin
            r.operation = OP_INB;
        end else if (opc == OPC_OUTB && f7 == F7_ZERO && rs1 == 5'd0 && f3 == F3_ZERO
                     && rd == 5'd0) begin
            r.operation = OP_OUTB;
        end else if (opc == OPC_IMM && f3 == F3_ZERO) begin
            r.operation = OP_ADDI;
            r.immediate = i_imm;
        end else if (opc == OPC_IMM && f3 == F3_ONE && f7 == F7_ZERO) begin
            r.operation = OP_SLLI;
            r.immediate = {27'd0, rs2};
        end else if (opc == OPC_IMM && f3 == F3_FIVE && f7 == F7_ALT) begin
            r.operation = OP_SRAI;
            r.immediate = {27'd0, rs2};
        end else if (opc == OPC_LOAD && f3 == F3_TWO) begin
            r.operation = OP_LW;
            r.immediate = i_imm;
        end else if (opc == OPC_FLOAD && f3 == F3_TWO) begin
            r.operation = OP_FLW;
            r.immediate = i_imm;
        end else if (opc == OPC_JALR && f3 == F3_ZERO) begin
            r.operation = OP_JALR;
            r.immediate = i_imm;
        end else begin
            bad = 1'b1;
        end
        if (bad) begin
            r.operation = OP_ADD;
            r.immediate = '0;
            r.status    = ST_INVALID;
        end
        return r;
    endfunction

    function automatic logic [31:0] with_funct(input logic [31:0] w, input logic [6:0] opc,
                                               input logic [2:0] f3, input logic [6:0] f7);
        return {f7, w[24:15], f3, w[11:7], opc};
    endfunction

    // valid encoding of one operation; fill sets the free bits
    function automatic logic [31:0] make_word(input op_t op, input fill_t fill);
        logic [31:0] w;
        case (fill)
            FILL_ZERO: w = '0;
            FILL_ONES: w = '1;
            default:   w = $urandom;
        endcase
        case (op)
            OP_ADD:    w = with_funct(w, OPC_REG, F3_ZERO, F7_ZERO);
            OP_SUB:    w = with_funct(w, OPC_REG, F3_ZERO, F7_ALT);
            OP_OR:     w = with_funct(w, OPC_REG, F3_SIX, F7_ZERO);
            OP_FADD:   w = with_funct(w, OPC_FP, F3_ZERO, F7_FADD);
            OP_FSUB:   w = with_funct(w, OPC_FP, F3_ZERO, F7_FSUB);
            OP_FMUL:   w = with_funct(w, OPC_FP, F3_ZERO, F7_FMUL);
            OP_FDIV:   w = with_funct(w, OPC_FP, F3_ZERO, F7_FDIV);
            OP_FSQRT:  w = with_funct({w[31:25], 5'd0, w[19:0]}, OPC_FP, F3_ZERO, F7_FSQRT);
            OP_FSGNJ:  w = with_funct(w, OPC_FP, F3_ZERO, F7_FSGNJ);
            OP_FSGNJN: w = with_funct(w, OPC_FP, F3_ONE, F7_FSGNJ);
            OP_FSGNJX: w = with_funct(w, OPC_FP, F3_TWO, F7_FSGNJ);
            OP_FCVTWS: w = with_funct({w[31:25], 5'd0, w[19:0]}, OPC_FP, F3_ZERO, F7_FCVTW);
            OP_FEQ:    w = with_funct(w, OPC_FP, F3_TWO, F7_FCMP);
            OP_FLE:    w = with_funct(w, OPC_FP, F3_ZERO, F7_FCMP);
            OP_FCVTSW: w = with_funct({w[31:25], 5'd0, w[19:0]}, OPC_FP, F3_ZERO, F7_FCVTS);
            OP_FMVSX:  w = with_funct({w[31:25], 5'd0, w[19:0]}, OPC_FP, F3_ZERO, F7_FMVSX);
            OP_SW:     w = with_funct(w, OPC_STORE, F3_TWO, w[31:25]);
            OP_FSW:    w = with_funct(w, OPC_FSTORE, F3_TWO, w[31:25]);
            OP_BEQ:    w = with_funct(w, OPC_BRANCH, F3_ZERO, w[31:25]);
            OP_BNE:    w = with_funct(w, OPC_BRANCH, F3_ONE, w[31:25]);
            OP_BLT:    w = with_funct(w, OPC_BRANCH, F3_FOUR, w[31:25]);
            OP_BGE:    w = with_funct(w, OPC_BRANCH, F3_FIVE, w[31:25]);
            OP_LUI:    w = {w[31:7], OPC_LUI};
            OP_JAL:    w = {w[31:7], OPC_JAL};
            OP_HALT:   w = '0;
            OP_INB:    w = {20'd0, w[11:7], OPC_INB};
            OP_OUTB:   w = {7'd0, w[24:20], 13'd0, OPC_OUTB};
            OP_ADDI:   w = with_funct(w, OPC_IMM, F3_ZERO, w[31:25]);
            OP_SLLI:   w = with_funct(w, OPC_IMM, F3_ONE, F7_ZERO);
            OP_SRAI:   w = with_funct(w, OPC_IMM, F3_FIVE, F7_ALT);
            OP_LW:     w = with_funct(w, OPC_LOAD, F3_TWO, w[31:25]);
            OP_FLW:    w = with_funct(w, OPC_FLOAD, F3_TWO, w[31:25]);
            OP_JALR:   w = with_funct(w, OPC_JALR, F3_ZERO, w[31:25]);
            default:   w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] random_pc();
        int unsigned sel;
        logic [31:0] idx;
        sel = $urandom_range(0, 9);
        if (program_words_model != 0 && sel < 7)
            idx = $urandom_range(0, int'(program_words_model) - 1);
        else if (program_words_model != 0 && sel == 7)
            idx = 32'(program_words_model) - 32'd1;
        else if (sel == 8)
            idx = 32'(program_words_model);
        else
            return $urandom;
        return {idx[29:0], 2'($urandom_range(0, 3))};
    endfunction

    // mostly well-formed words, some single-bit corruptions and raw noise
    function automatic logic [31:0] random_word();
        int unsigned sel;
        logic [31:0] w;
        sel = $urandom_range(0, 19);
        w = make_word(op_t'($urandom_range(0, OP_JALR)), FILL_RANDOM);
        if (sel >= 17)
            w = $urandom;
        else if (sel >= 14)
            w[$urandom_range(7, 31)] ^= 1'b1;
        return w;
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_decode(input logic [OUT_TDATA_WIDTH-1:0] data);
        result_t got;
        result_t want;
        got = result_t'(data[$bits(result_t)-1:0]);
        if (pending_decodes.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, actual %h",
                     $time, data);
            mismatch_count++;
            return;
        end
        want = pending_decodes.pop_front();
        compare_field("operation", 32'(want.operation), 32'(got.operation));
        compare_field("dest_reg", 32'(want.dest_reg), 32'(got.dest_reg));
        compare_field("src1_reg", 32'(want.src1_reg), 32'(got.src1_reg));
        compare_field("src2_reg", 32'(want.src2_reg), 32'(got.src2_reg));
        compare_field("immediate", want.immediate, got.immediate);
        compare_field("status", 32'(want.status), 32'(got.status));
        compare_field("pad", 32'd0, 32'(data >> $bits(result_t)));
    endfunction

    // result side: checks each transfer and stalls on its own pattern
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_decode(m_tdata);
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            if (ready_phase_left == 0) begin
                ready_mode       = $urandom_range(0, 3);
                ready_phase_left = $urandom_range(1, 48);
            end
            ready_phase_left--;
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ~m_tready;
            endcase
        end
    end

    task automatic send_instruction(input logic [31:0] pc, input logic [31:0] word);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {word, pc};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_decodes.push_back(decode_instruction(pc, word));
        burst_left--;
    endtask

    task automatic wait_drained();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending_decodes.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_program_words(input logic [PROG_WIDTH-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        program_words_model = value;
    endtask

    task automatic test_reset_size();
        send_instruction(32'd0, make_word(OP_ADD, FILL_ZERO));
        send_instruction(32'd3, 32'd0);
        send_instruction($urandom, make_word(OP_JAL, FILL_RANDOM));
        send_instruction($urandom, $urandom);
    endtask

    task automatic test_every_operation();
        write_program_words(PROG_WIDTH'(64));
        for (int i = 0; i <= OP_JALR; i++)
            send_instruction({i[29:0], 2'b11}, make_word(op_t'(i), FILL_ONES));
    endtask

    task automatic test_special_cases();
        logic [31:0] w;
        write_program_words(PROG_WIDTH'(16));
        // last word in range, first word out of range
        send_instruction(32'h0000_003f, make_word(OP_OR, FILL_ONES));
        send_instruction(32'h0000_0040, make_word(OP_OR, FILL_ONES));
        send_instruction(32'hffff_ffff, 32'd0);
        send_instruction(32'd0, 32'd0);
        send_instruction(32'd4, 32'hffff_ffff);
        // positive immediate extremes
        send_instruction(32'd8, make_word(OP_JAL, FILL_ONES) & 32'h7fff_ffff);
        send_instruction(32'd12, make_word(OP_ADDI, FILL_ONES) & 32'h7fff_ffff);
        send_instruction(32'd16, make_word(OP_BGE, FILL_ZERO));
        // near misses of otherwise valid encodings
        w = make_word(OP_INB, FILL_ONES);
        w[15] = 1'b1;
        send_instruction(32'd20, w);
        w = make_word(OP_OUTB, FILL_ONES);
        w[7] = 1'b1;
        send_instruction(32'd24, w);
        w = make_word(OP_FSQRT, FILL_ONES);
        w[20] = 1'b1;
        send_instruction(32'd28, w);
        w = make_word(OP_SW, FILL_ONES);
        w[14:12] = F3_ONE;
        send_instruction(32'd32, w);
        w = make_word(OP_SLLI, FILL_ONES);
        w[25] = 1'b1;
        send_instruction(32'd36, w);
    endtask

    task automatic test_random_stream(input logic [PROG_WIDTH-1:0] size, input int count);
        write_program_words(size);
        for (int i = 0; i < count; i++)
            send_instruction(random_pc(), random_word());
    endtask

    task automatic test_output_stall();
        write_program_words(PROG_WIDTH'(1 << 30));
        hold_requests++;
        for (int i = 0; i < 40; i++)
            send_instruction(random_pc(), random_word());
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_size();
        test_every_operation();
        test_special_cases();
        test_random_stream(PROG_WIDTH'(1 << 30), 400);
        test_output_stall();
        test_random_stream(PROG_WIDTH'(1), 150);
        test_random_stream(PROG_WIDTH'(0), 40);
        test_random_stream(PROG_WIDTH'(64), 300);
        test_random_stream(PROG_WIDTH'($urandom_range(2, 1 << 30)), 300);
        test_random_stream(PROG_WIDTH'((1 << 30) - 1), 300);
        wait_drained();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

endmodule
